### src/sha_pkg.sv
// ---------------------------------------------------------------------------
// sha_pkg: shared types and constants for the SHA-256 byte stream hasher
// Working state type, round constants, initial hash values and the
// sigma helper functions used by the round unit.
// ---------------------------------------------------------------------------
package sha_pkg;

	// index 0 is working variable a, index 7 is h
	typedef logic [7:0][31:0] state_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam state_t INIT_CHAIN = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [7:0] MARK_BYTE = 8'h80;
	localparam logic [5:0] PAD_END   = 6'd56;
	localparam logic [5:0] FILL_LAST = 6'd63;

	function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] r);
		return (x >> r) | (x << (6'd32 - {1'b0, r}));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return rotr(x, 5'd2) ^ rotr(x, 5'd13) ^ rotr(x, 5'd22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return rotr(x, 5'd6) ^ rotr(x, 5'd11) ^ rotr(x, 5'd25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
	endfunction

endpackage

### src/sha_round.sv
// ---------------------------------------------------------------------------
// sha_round: one SHA-256 compression round
// Advances the eight working words by one round and forms the next
// schedule word from the taps of the rolling 16-word window.
// ---------------------------------------------------------------------------
module sha_round (
	input  sha_pkg::state_t v,
	input  logic [31:0]     k,
	input  logic [31:0]     w0,
	input  logic [31:0]     w1,
	input  logic [31:0]     w9,
	input  logic [31:0]     w14,
	output sha_pkg::state_t v_nx,
	output logic [31:0]     w_new
);

	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] t1;
	logic [31:0] t2;

	assign ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
	assign maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
	assign t1  = v[7] + sha_pkg::big_sigma1(v[4]) + ch + k + w0;
	assign t2  = sha_pkg::big_sigma0(v[0]) + maj;

	always_comb begin
		v_nx[0] = t1 + t2;
		v_nx[1] = v[0];
		v_nx[2] = v[1];
		v_nx[3] = v[2];
		v_nx[4] = v[3] + t1;
		v_nx[5] = v[4];
		v_nx[6] = v[5];
		v_nx[7] = v[6];
	end

	// word sixteen places ahead of the one used this round
	assign w_new = sha_pkg::small_sigma1(w14) + w9 + sha_pkg::small_sigma0(w1) + w0;

endmodule

### src/sha_outbuf.sv
// ---------------------------------------------------------------------------
// sha_outbuf: digest output buffer
// Holds one 256-bit digest and hands it out as four 64-bit beats,
// most significant word first, so the hasher can go on absorbing.
// ---------------------------------------------------------------------------
module sha_outbuf (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  logic [255:0] digest,
	output logic         busy,
	output logic         result_valid,
	input  logic         result_stall,
	output logic [63:0]  digest_word,
	output logic [1:0]   word_index,
	output logic         last_word
);

	logic [255:0] data_q;
	logic [1:0]   idx_q;
	logic         valid_q;
	logic         take;

	assign take = valid_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
			if (idx_q == 2'd3) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= digest;
		end else if (take) begin
			data_q <= {data_q[191:0], 64'd0};
		end
	end

	assign busy         = valid_q;
	assign result_valid = valid_q;
	assign digest_word  = data_q[255:192];
	assign word_index   = idx_q;
	assign last_word    = (idx_q == 2'd3);

endmodule

### src/sha256_byte_stream_hasher_top.sv
// ---------------------------------------------------------------------------
// sha256_byte_stream_hasher_top: SHA-256 over a byte stream
// Absorbs message bytes, pads on finish and returns the digest as four
// big-endian 64-bit beats.
// ---------------------------------------------------------------------------
// An absorb beat is accepted while idle; the one that completes a 64-byte
// block starts a compression and stalls the input through 64 rounds on the
// single round unit and the add into the chaining values. A finish beat
// pushes the padding one byte per cycle (marker, zero fill up to byte 56,
// eight length bytes), then compresses the block. When the buffer already
// held 56 or more bytes the marker block is closed first and a whole zero
// block follows.
// The digest goes into an output buffer and drains as four beats while new
// bytes are absorbed; a second finish waits at its final add until that
// buffer is empty. There is no clearing pass after reset.
module sha256_byte_stream_hasher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        action,
	input  logic [7:0]  data_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [63:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MARK  = 3'd1;
	localparam logic [2:0] S_ZERO  = 3'd2;
	localparam logic [2:0] S_LEN   = 3'd3;
	localparam logic [2:0] S_ROUND = 3'd4;
	localparam logic [2:0] S_FOLD  = 3'd5;

	logic [2:0]      state_q;
	logic [5:0]      fill_q;
	logic [63:0]     count_q;
	logic [5:0]      rnd_q;
	logic [2:0]      len_idx_q;
	logic            zero_q;
	logic            fin_q;
	sha_pkg::state_t chain_q;
	sha_pkg::state_t v_q;
	logic [511:0]    buf_q;

	logic            item_acc;
	logic            push_en;
	logic [7:0]      push_byte;
	logic [63:0]     bit_len;
	logic [7:0]      len_byte;
	sha_pkg::state_t v_nx;
	logic [31:0]     w_new;
	sha_pkg::state_t sum;
	logic [255:0]    digest;
	logic            out_busy;
	logic            out_load;

	assign item_stall = (state_q != S_IDLE);
	assign item_acc   = item_valid && !item_stall;

	assign bit_len  = {count_q[60:0], 3'b000};
	assign len_byte = bit_len[{~len_idx_q, 3'b000} +: 8];

	always_comb begin
		push_en   = 1'b0;
		push_byte = 8'h00;
		case (state_q)
			S_IDLE: begin
				if (item_acc && !action) begin
					push_en   = 1'b1;
					push_byte = data_byte;
				end
			end
			S_MARK: begin
				push_en   = 1'b1;
				push_byte = sha_pkg::MARK_BYTE;
			end
			S_ZERO: begin
				push_en = (fill_q != sha_pkg::PAD_END);
			end
			S_LEN: begin
				push_en   = 1'b1;
				push_byte = len_byte;
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
	end

	// window word 0 sits at the top of the buffer
	sha_round u_round (
		.v     (v_q),
		.k     (sha_pkg::ROUND_K[rnd_q]),
		.w0    (buf_q[511:480]),
		.w1    (buf_q[479:448]),
		.w9    (buf_q[223:192]),
		.w14   (buf_q[63:32]),
		.v_nx  (v_nx),
		.w_new (w_new)
	);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			sum[i] = chain_q[i] + v_q[i];
		end
	end

	assign digest = {sum[0], sum[1], sum[2], sum[3], sum[4], sum[5], sum[6], sum[7]};
	assign out_load = (state_q == S_FOLD) && fin_q && !out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= 6'd0;
			count_q   <= 64'd0;
			rnd_q     <= 6'd0;
			len_idx_q <= 3'd0;
			zero_q    <= 1'b0;
			fin_q     <= 1'b0;
			chain_q   <= sha_pkg::INIT_CHAIN;
		end else begin
			if (push_en) begin
				fill_q <= fill_q + 6'd1;
			end
			case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						if (action) begin
							state_q <= S_MARK;
						end else begin
							count_q <= count_q + 64'd1;
							if (fill_q == sha_pkg::FILL_LAST) begin
								state_q <= S_ROUND;
								zero_q  <= 1'b0;
								fin_q   <= 1'b0;
							end
						end
					end
				end
				S_MARK: begin
					if (fill_q == sha_pkg::FILL_LAST) begin
						state_q <= S_ROUND;
						zero_q  <= 1'b1;
						fin_q   <= 1'b0;
					end else begin
						state_q <= S_ZERO;
					end
				end
				S_ZERO: begin
					if (fill_q == sha_pkg::PAD_END) begin
						state_q   <= S_LEN;
						len_idx_q <= 3'd0;
					end else if (fill_q == sha_pkg::FILL_LAST) begin
						state_q <= S_ROUND;
						zero_q  <= 1'b1;
						fin_q   <= 1'b0;
					end
				end
				S_LEN: begin
					len_idx_q <= len_idx_q + 3'd1;
					if (len_idx_q == 3'd7) begin
						state_q <= S_ROUND;
						zero_q  <= 1'b0;
						fin_q   <= 1'b1;
					end
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					if (!fin_q) begin
						chain_q <= sum;
						state_q <= zero_q ? S_ZERO : S_IDLE;
					end else if (!out_busy) begin
						// digest handed off, start the next message
						chain_q <= sha_pkg::INIT_CHAIN;
						count_q <= 64'd0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			buf_q <= {buf_q[503:0], push_byte};
		end else if (state_q == S_ROUND) begin
			buf_q <= {buf_q[479:0], w_new};
		end
		// working words hold through the final add while it waits
		if (state_q == S_ROUND) begin
			v_q <= v_nx;
		end else if (state_q != S_FOLD) begin
			v_q <= chain_q;
		end
	end

	sha_outbuf u_outbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (out_load),
		.digest       (digest),
		.busy         (out_busy),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.last_word    (last_word)
	);

	a_finish_starts_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && action) |=> (state_q == S_MARK))
		else $error("finish beat did not start padding");

	a_block_full_compress: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && !action && fill_q == sha_pkg::FILL_LAST) |=> (state_q == S_ROUND))
		else $error("full block did not start compression");

	a_len_position: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LEN) |-> (fill_q == {3'b111, len_idx_q}))
		else $error("length bytes out of place");

	a_rounds_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND && rnd_q == 6'd63) |=> (state_q == S_FOLD && rnd_q == 6'd0))
		else $error("round count slipped");

	a_digest_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (result_valid && word_index == 2'd0 && state_q == S_IDLE))
		else $error("digest not handed to output buffer");

endmodule

### tb/sv/tb_sha256_byte_stream_hasher_top.sv
// ---------------------------------------------------------------------------
// tb_sha256_byte_stream_hasher_top: self-checking bench for the byte hasher
// Feeds messages as absorb beats closed by a finish beat. An in-bench SHA-256
// model predicts the four digest beats of every message, and each digest
// beat is checked against them in order. The run steps through phases with
// and without source gaps and sink stalls.
// ---------------------------------------------------------------------------
module tb_sha256_byte_stream_hasher_top;

	localparam logic ACT_ABSORB = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	localparam logic [31:0] ROUND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		logic [63:0] word;
		logic [1:0]  idx;
		logic        last;
	} digest_beat_t;

	class digest_tracker;
		logic [31:0]  chain [8];
		logic [7:0]   blk [64];
		logic [63:0]  nbytes;
		digest_beat_t expected_words [$];
		int           errors;
		int           beats_in;
		int           messages;
		int           words_checked;

		function new();
			chain = INIT_HASH;
			foreach (blk[i]) blk[i] = 8'h00;
			nbytes = 64'd0;
			errors = 0;
			beats_in = 0;
			messages = 0;
			words_checked = 0;
		endfunction

		function logic [31:0] ror(input logic [31:0] x, input int r);
			return (x >> r) | (x << (32 - r));
		endfunction

		function void compress();
			logic [31:0] w [16];
			logic [31:0] v [8];
			logic [31:0] t1, t2, x, y;
			int          t;
			for (t = 0; t < 16; t++)
				w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
			v = chain;
			for (t = 0; t < 64; t++) begin
				if (t >= 16) begin
					// rolling schedule: slot t%16 holds w[t-16] until overwritten
					x = w[(t + 1) % 16];
					y = w[(t + 14) % 16];
					w[t % 16] = w[t % 16] + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3))
						+ w[(t + 9) % 16] + (ror(y, 17) ^ ror(y, 19) ^ (y >> 10));
				end
				t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + w[t % 16];
				t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (t = 0; t < 8; t++)
				chain[t] = chain[t] + v[t];
		endfunction

		// advance the model by one accepted input beat
		function void note_item(input logic act, input logic [7:0] b);
			logic [5:0]   fill;
			logic [63:0]  bit_len;
			digest_beat_t e;
			int           i;
			beats_in++;
			fill = nbytes[5:0];
			if (act == ACT_ABSORB) begin
				blk[fill] = b;
				nbytes = nbytes + 64'd1;
				if (fill == 6'd63)
					compress();
				return;
			end
			messages++;
			bit_len = nbytes << 3;
			blk[fill] = 8'h80;
			for (i = fill + 1; i < 64; i++)
				blk[i] = 8'h00;
			// no room left for the length field: spill into an extra block
			if (fill >= 6'd56) begin
				compress();
				for (i = 0; i < 56; i++)
					blk[i] = 8'h00;
			end
			for (i = 0; i < 8; i++)
				blk[56 + i] = bit_len[63 - 8*i -: 8];
			compress();
			for (i = 0; i < 4; i++) begin
				e.word = {chain[2*i], chain[2*i + 1]};
				e.idx  = i[1:0];
				e.last = (i == 3);
				expected_words.push_back(e);
			end
			chain = INIT_HASH;
			nbytes = 64'd0;
		endfunction

		task report_mismatch(input string what);
			$display("%0t mismatch: %s", $realtime, what);
			errors++;
		endtask

		task check_word(input logic [63:0] word, input logic [1:0] idx, input logic last);
			digest_beat_t e;
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("unexpected digest beat %h idx %0d", word, idx));
				return;
			end
			e = expected_words.pop_front();
			words_checked++;
			if (word !== e.word)
				report_mismatch($sformatf("digest_word %h, want %h", word, e.word));
			if (idx !== e.idx)
				report_mismatch($sformatf("word_index %0d, want %0d", idx, e.idx));
			if (last !== e.last)
				report_mismatch($sformatf("last_word %b, want %b", last, e.last));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        action = ACT_ABSORB;
	logic [7:0]  data_byte = 8'h00;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [63:0] digest_word;
	logic [1:0]  word_index;
	logic        last_word;

	int src_idle = 0;
	int sink_stall = 0;

	digest_tracker sb = new();

	sha256_byte_stream_hasher_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.action       (action),
		.data_byte    (data_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.last_word    (last_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		result_stall <= ($urandom_range(0, 99) < sink_stall);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_word(digest_word, word_index, last_word);
	end

	// called and returns at a falling edge
	task automatic send_beat(input logic act, input logic [7:0] b);
		while ($urandom_range(0, 99) < src_idle) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		action     <= act;
		data_byte  <= b;
		do @(posedge clk); while (item_stall);
		sb.note_item(act, b);
		@(negedge clk);
	endtask

	// hold the source off until every digest beat has come out
	task automatic drain_pause();
		item_valid <= 1'b0;
		while (sb.expected_words.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int ph;
		int len;
		int rand_beats;
		int n;
		int phase_end [4];
		phase_end = '{15, 75, 140, 155};
		rand_beats = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty message, finish byte ignored
		send_beat(ACT_FINISH, 8'hff);
		send_beat(ACT_ABSORB, 8'h61);
		send_beat(ACT_ABSORB, 8'h62);
		send_beat(ACT_ABSORB, 8'h63);
		send_beat(ACT_FINISH, 8'h00);
		send_beat(ACT_ABSORB, 8'h00);
		send_beat(ACT_ABSORB, 8'hff);
		send_beat(ACT_ABSORB, 8'h80);
		send_beat(ACT_FINISH, 8'h5a);
		// back-to-back finishes: the second one closes an empty message
		send_beat(ACT_FINISH, 8'h00);
		send_beat(ACT_FINISH, 8'hff);
		send_beat(ACT_ABSORB, 8'h55);
		send_beat(ACT_ABSORB, 8'haa);
		send_beat(ACT_FINISH, 8'h01);
		drain_pause();

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle = 0;  sink_stall = 0;  end
				1: begin src_idle = 68; sink_stall = 0;  end
				2: begin src_idle = 0;  sink_stall = 68; end
				default: begin src_idle = 8; sink_stall = 8; end
			endcase
			// long messages put the finish at fill 56 and fill 63
			if (ph == 1)
				len = 56;
			else if (ph == 2)
				len = 63;
			else
				len = $urandom_range(0, 24);
			while (rand_beats < phase_end[ph]) begin
				repeat (len) begin
					send_beat(ACT_ABSORB, 8'($urandom_range(0, 255)));
					rand_beats++;
				end
				send_beat(ACT_FINISH, 8'($urandom_range(0, 255)));
				rand_beats++;
				if ($urandom_range(0, 7) == 0)
					len = $urandom_range(0, 70);
				else
					len = $urandom_range(0, 24);
			end
			drain_pause();
		end

		item_valid <= 1'b0;
		n = 0;
		while (sb.expected_words.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (300) @(posedge clk);
		if (sb.expected_words.size() != 0)
			sb.report_mismatch($sformatf("%0d digest beats never came",
				sb.expected_words.size()));
		$display("covered %0d input beats in %0d messages, %0d digest beats checked",
			sb.beats_in, sb.messages, sb.words_checked);
		$display("phases: no gaps, source gaps, sink stalls, both; %0d mismatches", sb.errors);
		if (sb.errors == 0)
			$display("tb_sha256_byte_stream_hasher_top: clean");
		else
			$display("tb_sha256_byte_stream_hasher_top: errors");
		$finish;
	end

	initial begin
		#5000000;
		$display("tb_sha256_byte_stream_hasher_top: errors");
		$finish;
	end

endmodule
